@@ sv/round_trip_statistics_defines.svh @@
// Assertion helpers shared by the round-trip statistics RTL.
`ifndef ROUND_TRIP_STATISTICS_DEFINES_SVH
`define ROUND_TRIP_STATISTICS_DEFINES_SVH

// Checked at every clock edge outside reset.
`define RTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define RTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rts_pkg.sv @@
`default_nettype none

package rts_pkg;

  localparam int unsigned RTT_BITS_DEF   = 20;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

endpackage

`default_nettype wire

@@ sv/rts_if.sv @@
`default_nettype none

interface rts_in_if #(
  parameter int unsigned RTT_BITS = rts_pkg::RTT_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [RTT_BITS-1:0] rtt_us;

  modport source (output valid, output rtt_us, input ready);
  modport sink   (input valid, input rtt_us, output ready);
endinterface

interface rts_out_if #(
  parameter int unsigned RTT_BITS   = rts_pkg::RTT_BITS_DEF,
  parameter int unsigned COUNT_BITS = rts_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [RTT_BITS-1:0]   min_us;
  logic [RTT_BITS-1:0]   max_us;
  logic [RTT_BITS-1:0]   mean_us;
  logic [RTT_BITS-1:0]   stddev_us;
  logic [COUNT_BITS-1:0] sample_count;
  logic                  dropped;

  modport source (
    output valid, output min_us, output max_us, output mean_us, output stddev_us,
    output sample_count, output dropped, input ready
  );
  modport sink (
    input valid, input min_us, input max_us, input mean_us, input stddev_us,
    input sample_count, input dropped, output ready
  );
endinterface

`default_nettype wire

@@ sv/rts_front.sv @@
`default_nettype none
`include "round_trip_statistics_defines.svh"

module rts_front #(
  parameter int unsigned RTT_BITS   = 20,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SNAP_BITS  = 5 * RTT_BITS + 3 * COUNT_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rts_in_if.sink               rtt_i,
  output logic                 snap_valid_o,
  input  logic                 snap_ready_i,
  output logic [SNAP_BITS-1:0] snap_o
);

  localparam int unsigned SUM_BITS = RTT_BITS + COUNT_BITS;
  localparam int unsigned SQ_BITS  = 2 * RTT_BITS + COUNT_BITS;

  logic                    stage_q;
  logic [RTT_BITS-1:0]     rtt_q;
  logic [2*RTT_BITS-1:0]   sq_q;
  logic [RTT_BITS-1:0]     min_q, min_d;
  logic [RTT_BITS-1:0]     max_q, max_d;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic [SQ_BITS-1:0]      sumsq_q, sumsq_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic                    drop;
  logic                    accept;
  logic                    push;

  assign rtt_i.ready  = !stage_q;
  assign accept       = rtt_i.valid && !stage_q;
  assign snap_valid_o = stage_q;
  assign push         = stage_q && snap_ready_i;
  assign drop         = &count_q;

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    sum_d   = sum_q;
    sumsq_d = sumsq_q;
    count_d = count_q;
    if (!drop) begin
      min_d   = (rtt_q < min_q) ? rtt_q : min_q;
      max_d   = (rtt_q > max_q) ? rtt_q : max_q;
      sum_d   = sum_q + {{COUNT_BITS{1'b0}}, rtt_q};
      sumsq_d = sumsq_q + {{COUNT_BITS{1'b0}}, sq_q};
      count_d = count_q + 1'b1;
    end
  end

  assign snap_o = {drop, count_d, sumsq_d, sum_d, max_d, min_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      min_q   <= '1;
      max_q   <= '0;
      sum_q   <= '0;
      sumsq_q <= '0;
      count_q <= '0;
    end else begin
      if (accept) begin
        stage_q <= 1'b1;
      end else if (push) begin
        stage_q <= 1'b0;
      end
      if (push) begin
        min_q   <= min_d;
        max_q   <= max_d;
        sum_q   <= sum_d;
        sumsq_q <= sumsq_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rtt_q <= rtt_i.rtt_us;
      sq_q  <= {{RTT_BITS{1'b0}}, rtt_i.rtt_us} * {{RTT_BITS{1'b0}}, rtt_i.rtt_us};
    end
  end

  `RTS_ASSERT(a_count_monotonic, clk_i, rst_ni, count_q >= $past(count_q), "Sample count went down.")
  `RTS_ASSERT(a_min_le_max, clk_i, rst_ni, (count_q == '0) || (min_q <= max_q), "Minimum exceeds maximum.")

endmodule

`default_nettype wire

@@ sv/rts_fifo.sv @@
`default_nettype none
`include "round_trip_statistics_defines.svh"

module rts_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `RTS_ASSERT_ALWAYS(a_fill_in_range, clk_i, !rst_ni || cnt_q <= CW'(DEPTH), "Fill count out of range.")

endmodule

`default_nettype wire

@@ sv/rts_div.sv @@
`default_nettype none

module rts_div #(
  parameter int unsigned QBITS = 20,
  parameter int unsigned DBITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DBITS-1:0] rem_init_i,
  input  logic [QBITS-1:0] num_i,
  input  logic [DBITS-1:0] den_i,
  output logic             busy_o,
  output logic [QBITS-1:0] quo_o
);

  localparam int unsigned CW = $clog2(QBITS + 1);

  logic             busy_q;
  logic [CW-1:0]    cnt_q;
  logic [DBITS-1:0] rem_q;
  logic [DBITS-1:0] den_q;
  logic [QBITS-1:0] quo_q;
  logic [DBITS:0]   rem_t;
  logic [DBITS:0]   rem_sub;
  logic             fits;

  assign rem_t   = {rem_q, quo_q[QBITS-1]};
  assign fits    = rem_t >= {1'b0, den_q};
  assign rem_sub = rem_t - {1'b0, den_q};
  assign busy_o  = busy_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QBITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[DBITS-1:0] : rem_t[DBITS-1:0];
      quo_q <= {quo_q[QBITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ sv/rts_back.sv @@
`default_nettype none
`include "round_trip_statistics_defines.svh"

module rts_back #(
  parameter int unsigned RTT_BITS   = 20,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SNAP_BITS  = 5 * RTT_BITS + 3 * COUNT_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 snap_valid_i,
  output logic                 snap_ready_o,
  input  logic [SNAP_BITS-1:0] snap_i,
  rts_out_if.source            stat_o
);

  localparam int unsigned R  = RTT_BITS;
  localparam int unsigned C  = COUNT_BITS;
  localparam int unsigned SW = $clog2(R);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;

  logic [2:0]     state_q, state_d;
  logic           out_valid_q;
  logic           take;
  logic           load;

  logic           sum_busy, sq_busy;
  logic [R-1:0]   mean_quo;
  logic [2*R-1:0] sq_quo;

  logic [R-1:0]   min_q, max_q;
  logic [C-1:0]   cnt_q;
  logic           drop_q;
  logic [2*R-1:0] msq_q;
  logic [2*R-1:0] rad_q;
  logic [R+1:0]   rem_q;
  logic [R-1:0]   root_q;
  logic [SW-1:0]  step_q;
  logic [R+3:0]   rem_t, trial, rem_sub;
  logic           fits;

  logic [R-1:0]   min_out_q, max_out_q, mean_out_q, sd_out_q;
  logic [C-1:0]   cnt_out_q;
  logic           drop_out_q;

  assign snap_ready_o = (state_q == ST_IDLE);
  assign take         = snap_valid_i && snap_ready_o;
  assign load         = (state_q == ST_WAIT) && (!out_valid_q || stat_o.ready);

  rts_div #(.QBITS(R), .DBITS(C)) u_div_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take),
    .rem_init_i (snap_i[3*R+C-1:3*R]),
    .num_i      (snap_i[3*R-1:2*R]),
    .den_i      (snap_i[5*R+3*C-1:5*R+2*C]),
    .busy_o     (sum_busy),
    .quo_o      (mean_quo)
  );

  rts_div #(.QBITS(2 * R), .DBITS(C)) u_div_sq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (take),
    .rem_init_i (snap_i[5*R+2*C-1:5*R+C]),
    .num_i      (snap_i[5*R+C-1:3*R+C]),
    .den_i      (snap_i[5*R+3*C-1:5*R+2*C]),
    .busy_o     (sq_busy),
    .quo_o      (sq_quo)
  );

  assign rem_t   = {rem_q, rad_q[2*R-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign fits    = rem_t >= trial;
  assign rem_sub = rem_t - trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = ST_DIV;
      ST_DIV:  if (!sum_busy && !sq_busy) state_d = ST_SQR;
      ST_SQR:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_ROOT;
      ST_ROOT: if (step_q == '0) state_d = ST_WAIT;
      ST_WAIT: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (stat_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      min_q  <= snap_i[R-1:0];
      max_q  <= snap_i[2*R-1:R];
      cnt_q  <= snap_i[5*R+3*C-1:5*R+2*C];
      drop_q <= snap_i[5*R+3*C];
    end
    if (state_q == ST_SQR) begin
      msq_q <= {{R{1'b0}}, mean_quo} * {{R{1'b0}}, mean_quo};
    end
    if (state_q == ST_DIFF) begin
      rad_q  <= (sq_quo >= msq_q) ? (sq_quo - msq_q) : '0;
      rem_q  <= '0;
      root_q <= '0;
      step_q <= SW'(R - 1);
    end
    if (state_q == ST_ROOT) begin
      rad_q  <= {rad_q[2*R-3:0], 2'b00};
      rem_q  <= fits ? rem_sub[R+1:0] : rem_t[R+1:0];
      root_q <= {root_q[R-2:0], fits};
      step_q <= step_q - 1'b1;
    end
    if (load) begin
      min_out_q  <= min_q;
      max_out_q  <= max_q;
      mean_out_q <= (cnt_q == '0) ? '0 : mean_quo;
      sd_out_q   <= (cnt_q == '0) ? '0 : root_q;
      cnt_out_q  <= cnt_q;
      drop_out_q <= drop_q;
    end
  end

  assign stat_o.valid        = out_valid_q;
  assign stat_o.min_us       = min_out_q;
  assign stat_o.max_us       = max_out_q;
  assign stat_o.mean_us      = mean_out_q;
  assign stat_o.stddev_us    = sd_out_q;
  assign stat_o.sample_count = cnt_out_q;
  assign stat_o.dropped      = drop_out_q;

  `RTS_ASSERT(a_load_from_wait, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == ST_WAIT), "Result appeared outside the output step.")
  `RTS_ASSERT(a_mean_in_range, clk_i, rst_ni, out_valid_q |-> ((cnt_out_q == '0) || ((mean_out_q >= min_out_q) && (mean_out_q <= max_out_q))), "Mean lies outside the sample range.")

endmodule

`default_nettype wire

@@ sv/round_trip_statistics.sv @@
// Running round-trip statistics: each input word is one sample in microseconds, and each
// accepted word yields exactly one result word with the minimum, maximum, truncated mean,
// truncated population standard deviation and sample count, or, once the count is full,
// the unchanged statistics with the dropped flag set. The front end registers a word and
// its square, then, when a small queue takes the updated snapshot, folds the word into the
// accumulators. The back end divides the sum of squares by the count one quotient bit
// per cycle (with the mean division running alongside), squares the mean, subtracts,
// and takes the integer square root two bits per cycle. It takes a new snapshot only in
// its idle state, so it finishes one word before it starts the next. The output register
// lets a finished result wait while the next word is already being worked on.
`default_nettype none

module round_trip_statistics #(
  parameter int unsigned RTT_BITS   = rts_pkg::RTT_BITS_DEF,
  parameter int unsigned COUNT_BITS = rts_pkg::COUNT_BITS_DEF,
  parameter int unsigned FIFO_DEPTH = rts_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rts_in_if.sink     rtt_i,
  rts_out_if.source  stat_o
);

  localparam int unsigned SNAP_BITS = 5 * RTT_BITS + 3 * COUNT_BITS + 1;

  logic                 front_valid, front_ready;
  logic [SNAP_BITS-1:0] front_snap;
  logic                 back_valid, back_ready;
  logic [SNAP_BITS-1:0] back_snap;

  rts_front #(
    .RTT_BITS   (RTT_BITS),
    .COUNT_BITS (COUNT_BITS),
    .SNAP_BITS  (SNAP_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rtt_i        (rtt_i),
    .snap_valid_o (front_valid),
    .snap_ready_i (front_ready),
    .snap_o       (front_snap)
  );

  rts_fifo #(
    .WIDTH (SNAP_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_snap),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_snap)
  );

  rts_back #(
    .RTT_BITS   (RTT_BITS),
    .COUNT_BITS (COUNT_BITS),
    .SNAP_BITS  (SNAP_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (back_valid),
    .snap_ready_o (back_ready),
    .snap_i       (back_snap),
    .stat_o       (stat_o)
  );

endmodule

`default_nettype wire
